>>> design/correlated_deviate_perturbation_unit_defines.svh
// ---------------------------------------------------------------------------
// Correlated deviate perturbation unit: assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ---------------------------------------------------------------------------
`ifndef CORRELATED_DEVIATE_PERTURBATION_UNIT_DEFINES_SVH
`define CORRELATED_DEVIATE_PERTURBATION_UNIT_DEFINES_SVH

// Property checked while the block is out of reset.
`define CDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property checked at every edge, reset included.
`define CDP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/cdp_pkg.sv
// ---------------------------------------------------------------------------
// Correlated deviate perturbation package
// Opcodes, register indexes, field widths and the accumulator control struct.
// ---------------------------------------------------------------------------
package cdp_pkg;

    // Item operations carried in tuser.
    typedef enum logic [1:0] {
        OP_WR_NOMINAL = 2'd0,
        OP_WR_FACTOR  = 2'd1,
        OP_WR_DEVIATE = 2'd2,
        OP_ROW        = 2'd3
    } opcode_t;

    // Configuration register indexes.
    localparam logic CFG_SAMPLES = 1'b0;
    localparam logic CFG_HOLD    = 1'b1;

    // Fixed field widths.
    localparam int CORE_W   = 3;
    localparam int SAMPLE_W = 5;
    localparam int VALUE_W  = 32;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;      // load the rounding constant into the accumulator
        logic mul_valid;  // factor and deviate operands are valid this cycle
        logic add_nom;    // add the scaled nominal entry
    } mac_ctrl_t;

endpackage

>>> design/cdp_mac.sv
// ---------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One 32x32 signed multiplier feeding a wide accumulator, with rounding and
// saturation of the accumulated sum to a 32-bit fixed-point value.
// ---------------------------------------------------------------------------
module cdp_mac
    import cdp_pkg::*;
#(
    parameter int FRAC_BITS = 24,
    parameter int ACC_W     = 74
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [VALUE_W-1:0] fac_data,
    input  logic signed [VALUE_W-1:0] dev_data,
    input  logic signed [VALUE_W-1:0] nom_data,
    output logic                      busy,
    output logic signed [VALUE_W-1:0] result,
    output logic                      saturated
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic signed [2*VALUE_W-1:0] prod_reg;
    logic                        prod_v_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     addend;
    logic signed [ACC_W-1:0]     nom_ext;
    logic signed [ACC_W-1:0]     shifted;
    logic [ACC_W-VALUE_W:0]      upper;
    logic                        fits;

    // Multiplier stage, registered before the accumulator.
    always_ff @(posedge aclk) begin
        prod_reg <= fac_data * dev_data;
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= ctrl.mul_valid;
        end
    end

    assign busy = prod_v_reg;

    // The nominal entry is brought to the product scale before it is added.
    assign nom_ext = {{(ACC_W-VALUE_W){nom_data[VALUE_W-1]}}, nom_data} <<< FRAC_BITS;

    // One adder serves both the products and the nominal entry.
    always_comb begin
        addend   = ctrl.add_nom ? nom_ext
                                : {{(ACC_W-2*VALUE_W){prod_reg[2*VALUE_W-1]}}, prod_reg};
        acc_next = acc_reg;
        priority if (ctrl.clear) begin
            acc_next = HALF;
        end else if (ctrl.add_nom || prod_v_reg) begin
            acc_next = acc_reg + addend;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Round by truncation of the biased sum, then clip to 32 bits.
    always_comb begin
        shifted   = acc_reg >>> FRAC_BITS;
        upper     = shifted[ACC_W-1:VALUE_W-1];
        fits      = (&upper) || !(|upper);
        saturated = !fits;
        if (fits) begin
            result = shifted[VALUE_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            result = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

endmodule

>>> design/correlated_deviate_perturbation_unit.sv
// ---------------------------------------------------------------------------
// Correlated deviate perturbation unit
// Stores a nominal vector, a square factor matrix and a deviate vector, and
// returns one perturbed row y[i] = nominal[i] + sum_j F[i][j] * z[j] on request.
// ---------------------------------------------------------------------------
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_tvalid / s_tready  | s_tdata, s_tuser (opcode)
// m_       | out       | m_tvalid / m_tready  | m_tdata, m_tuser (saturated)
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A store item passes through the execute state, where it is written, before
// the next item is taken. A row request reads one factor and one deviate
// entry per cycle through the shared multiplier and accumulator, over CORES*n
// columns, n being the samples in use; in hold mode the reads are skipped.
// Reset is synchronous; the stores are not cleared. The finished result sits
// in the output register and waits there while m_tready is low.
// ---------------------------------------------------------------------------
`include "correlated_deviate_perturbation_unit_defines.svh"

module correlated_deviate_perturbation_unit
    import cdp_pkg::*;
#(
    parameter int CORES       = 6,
    parameter int SAMPLES_MAX = 32,
    parameter int FRAC_BITS   = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] row_core, [7:3] row_sample, [10:8] col_core, [15:11] col_sample,
    // [47:16] operand_value
    input  logic [47:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] out_core, [7:3] out_sample, [39:8] perturbed_value
    output logic [39:0] m_tdata,
    // [0] saturated
    output logic [0:0]  m_tuser,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int VEC_LEN   = CORES * SAMPLES_MAX;
    localparam int VEC_W     = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
    localparam int FAC_DEPTH = VEC_LEN * VEC_LEN;
    localparam int FAC_W     = $clog2(FAC_DEPTH);
    localparam int CNT_W     = $clog2(VEC_LEN + 1);
    localparam int SW        = $clog2(SAMPLES_MAX + 1);
    localparam int ACC_W     = 2 * VALUE_W + VEC_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MAC,
        ST_DRAIN,
        ST_ADDNOM,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic [5:0]     samples_reg;
    logic           hold_reg;
    logic [SW-1:0]  n_eff;

    // Sequencer and item registers
    state_t               state_reg, state_next;
    opcode_t              op_reg, op_next;
    logic [CORE_W-1:0]    rc_reg, rc_next;
    logic [SAMPLE_W-1:0]  rs_reg, rs_next;
    logic [VEC_W-1:0]     row_reg, row_next;
    logic [VEC_W-1:0]     col_reg, col_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic                 ok_reg, ok_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [FAC_W-1:0]     base_reg, base_next;
    logic                 rd_v_reg, rd_v_next;
    logic                 m_valid_reg, m_valid_next;
    logic [39:0]          m_data_reg, m_data_next;
    logic                 m_sat_reg, m_sat_next;

    // Decoded input fields
    opcode_t              in_op;
    logic [CORE_W-1:0]    in_rc, in_cc;
    logic [SAMPLE_W-1:0]  in_rs, in_cs;
    logic                 row_ok, col_ok;

    // Memories and their read data
    logic [VALUE_W-1:0] nom_mem [VEC_LEN];
    logic [VALUE_W-1:0] dev_mem [VEC_LEN];
    logic [VALUE_W-1:0] fac_mem [FAC_DEPTH];
    logic [VALUE_W-1:0] nom_q, dev_q, fac_q;
    logic [FAC_W-1:0]   row_base;
    logic [FAC_W-1:0]   fac_waddr, fac_raddr;
    logic               nom_we, dev_we, fac_we;

    // Accumulator interface
    mac_ctrl_t                 mac_ctrl;
    logic                      mac_busy;
    logic signed [VALUE_W-1:0] mac_result;
    logic                      mac_sat;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_reg <= 6'd32;
            hold_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SAMPLES: samples_reg <= cfg_data;
                CFG_HOLD:    hold_reg    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Samples in use, with zero read as one and large values clipped.
    always_comb begin
        priority if (samples_reg == 6'd0) begin
            n_eff = SW'(1);
        end else if (32'(samples_reg) > 32'(SAMPLES_MAX)) begin
            n_eff = SW'(SAMPLES_MAX);
        end else begin
            n_eff = SW'(samples_reg);
        end
    end

    // Field decode and index checks on the incoming item.
    assign in_op  = opcode_t'(s_tuser);
    assign in_rc  = s_tdata[2:0];
    assign in_rs  = s_tdata[7:3];
    assign in_cc  = s_tdata[10:8];
    assign in_cs  = s_tdata[15:11];
    assign row_ok = (32'(in_rc) < 32'(CORES)) && (32'(in_rs) < 32'(n_eff));
    assign col_ok = (32'(in_cc) < 32'(CORES)) && (32'(in_cs) < 32'(n_eff));

    // Factor addressing: row base plus column or loop index.
    assign row_base  = FAC_W'(32'(row_reg) * VEC_LEN);
    assign fac_waddr = row_base + FAC_W'(col_reg);
    assign fac_raddr = base_reg + FAC_W'(cnt_reg);

    assign nom_we = (state_reg == ST_EXEC) && ok_reg && (op_reg == OP_WR_NOMINAL);
    assign dev_we = (state_reg == ST_EXEC) && ok_reg && (op_reg == OP_WR_DEVIATE);
    assign fac_we = (state_reg == ST_EXEC) && ok_reg && (op_reg == OP_WR_FACTOR);

    // Nominal vector
    always_ff @(posedge aclk) begin
        if (nom_we) begin
            nom_mem[row_reg] <= val_reg;
        end
        nom_q <= nom_mem[row_reg];
    end

    // Deviate vector, read in column order during a row
    always_ff @(posedge aclk) begin
        if (dev_we) begin
            dev_mem[row_reg] <= val_reg;
        end
        dev_q <= dev_mem[cnt_reg[VEC_W-1:0]];
    end

    // Factor matrix, row major
    always_ff @(posedge aclk) begin
        if (fac_we) begin
            fac_mem[fac_waddr] <= val_reg;
        end
        fac_q <= fac_mem[fac_raddr];
    end

    // Accumulator control from the sequencer.
    always_comb begin
        mac_ctrl.clear     = (state_reg == ST_EXEC) && ok_reg && (op_reg == OP_ROW);
        mac_ctrl.mul_valid = rd_v_reg;
        mac_ctrl.add_nom   = (state_reg == ST_ADDNOM);
    end

    cdp_mac #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mac_ctrl),
        .fac_data  (fac_q),
        .dev_data  (dev_q),
        .nom_data  (nom_q),
        .busy      (mac_busy),
        .result    (mac_result),
        .saturated (mac_sat)
    );

    // Sequencer next state.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        rc_next      = rc_reg;
        rs_next      = rs_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        val_next     = val_reg;
        ok_next      = ok_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        rd_v_next    = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_sat_next   = m_sat_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = in_op;
                    rc_next    = in_rc;
                    rs_next    = in_rs;
                    row_next   = VEC_W'(32'(in_rc) * 32'(n_eff) + 32'(in_rs));
                    col_next   = VEC_W'(32'(in_cc) * 32'(n_eff) + 32'(in_cs));
                    val_next   = s_tdata[47:16];
                    ok_next    = row_ok && ((in_op != OP_WR_FACTOR) || col_ok);
                    total_next = CNT_W'(CORES * 32'(n_eff));
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Stores are written here; a row clears the accumulator.
                cnt_next  = '0;
                base_next = row_base;
                if (ok_reg && (op_reg == OP_ROW)) begin
                    state_next = hold_reg ? ST_DRAIN : ST_MAC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC: begin
                // One factor and deviate read per cycle.
                rd_v_next = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == total_reg - CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !mac_busy) begin
                    state_next = ST_ADDNOM;
                end
            end
            ST_ADDNOM: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {mac_result, rs_reg, rc_reg};
                    m_sat_next   = mac_sat;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        rc_reg     <= rc_next;
        rs_reg     <= rs_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        val_reg    <= val_next;
        ok_reg     <= ok_next;
        total_reg  <= total_next;
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        m_data_reg <= m_data_next;
        m_sat_reg  <= m_sat_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_v_reg    <= rd_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

    // A new item is only taken with the multiply pipeline empty.
    `CDP_ASSERT(a_ready_pipe_empty, s_tready |-> (!rd_v_reg && !mac_busy), "item taken with MAC busy")
    // The read index never runs past the columns in use.
    `CDP_ASSERT(a_cnt_in_range, (state_reg == ST_MAC) |-> (cnt_reg < total_reg), "column index overrun")
    // The result is taken only after every product has been added.
    `CDP_ASSERT(a_finish_drained, (state_reg == ST_FINISH) |-> (!rd_v_reg && !mac_busy), "result before drain")
    // A product in flight always comes from a read in the cycle before.
    `CDP_ASSERT(a_prod_from_read, mac_busy |-> $past(rd_v_reg), "product without read")
    // Reset empties the output register.
    `CDP_ASSERT_ALWAYS(a_reset_out, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

>>> tb/correlated_deviate_perturbation_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Correlated deviate perturbation unit testbench
// Loads nominal, factor and deviate entries through the item stream and asks
// for perturbed rows. A scoreboard class keeps its own copy of the three
// stores and of both registers, predicts every row, and checks each result
// transfer field by field. Stimulus runs through several register settings,
// with random idling on the input and output sides.
// ---------------------------------------------------------------------------
module correlated_deviate_perturbation_unit_tb
    import cdp_pkg::*;
();

    localparam int CORES        = 6;
    localparam int SAMPLES_MAX  = 32;
    localparam int FRAC_BITS    = 24;
    localparam int VEC_LEN      = CORES * SAMPLES_MAX;
    localparam int DRAIN_CYCLES = VEC_LEN + 16;

    localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_ONE  = 32'h0100_0000;
    localparam logic [31:0] VAL_HALF = 32'h0080_0000;
    localparam logic [31:0] VAL_NEG1 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  core;
        logic [4:0]  sample;
        logic [31:0] value;
        logic        sat;
    } row_result_t;

    // Scoreboard: mirrors the stores and registers and holds pending rows.
    class row_ledger;
        logic [31:0] nominal [VEC_LEN];
        logic [31:0] deviate [VEC_LEN];
        logic [31:0] factor  [VEC_LEN * VEC_LEN];
        bit          nominal_set [VEC_LEN];
        bit          deviate_set [VEC_LEN];
        bit          factor_set  [VEC_LEN * VEC_LEN];
        logic [5:0]  samples_reg = 6'd32;
        bit          hold_reg = 1'b0;
        row_result_t pending_rows [$];
        int unsigned mismatches = 0;
        int unsigned rows_checked = 0;
        int unsigned rows_saturated = 0;

        function void set_config(logic idx, logic [5:0] data);
            if (idx == CFG_SAMPLES) begin
                samples_reg = data;
            end else begin
                hold_reg = data[0];
            end
        endfunction

        // Effective samples per core after clamping.
        function int unsigned span();
            if (samples_reg == 0) return 1;
            if (samples_reg > SAMPLES_MAX) return SAMPLES_MAX;
            return 32'(samples_reg);
        endfunction

        // Row value: exact wide sum, round half up, saturate to 32 bits; hold mode returns the nominal entry.
        function row_result_t perturbed_row(logic [2:0] rc, logic [4:0] rs,
                                            int unsigned row, int unsigned n);
            row_result_t res;
            logic signed [127:0] acc;
            logic signed [127:0] scaled;
            logic signed [63:0]  prod;
            int unsigned j;
            res.core = rc;
            res.sample = rs;
            res.sat = 1'b0;
            if (hold_reg) begin
                res.value = nominal[row];
                return res;
            end
            acc = '0;
            for (j = 0; j < CORES * n; j++) begin
                prod = 64'($signed(factor[row * VEC_LEN + j])) * 64'($signed(deviate[j]));
                acc = acc + 128'(prod);
            end
            scaled = 128'($signed(nominal[row]));
            acc = acc + (scaled <<< FRAC_BITS) + (128'sd1 <<< (FRAC_BITS - 1));
            scaled = acc >>> FRAC_BITS;
            if (scaled > 128'sd2147483647) begin
                res.value = VAL_MAX;
                res.sat = 1'b1;
            end else if (scaled < -128'sd2147483648) begin
                res.value = VAL_MIN;
                res.sat = 1'b1;
            end else begin
                res.value = scaled[31:0];
            end
            return res;
        endfunction

        // Apply one accepted item; out-of-range indexes leave everything alone.
        function void note_item(opcode_t op, logic [2:0] rc, logic [4:0] rs,
                                logic [2:0] cc, logic [4:0] cs, logic [31:0] val);
            int unsigned n, row, col;
            n = span();
            if (rc >= CORES || rs >= n) return;
            row = rc * n + rs;
            col = cc * n + cs;
            case (op)
                OP_WR_NOMINAL: begin
                    nominal[row] = val;
                    nominal_set[row] = 1'b1;
                end
                OP_WR_DEVIATE: begin
                    deviate[row] = val;
                    deviate_set[row] = 1'b1;
                end
                OP_WR_FACTOR: begin
                    if (cc < CORES && cs < n) begin
                        factor[row * VEC_LEN + col] = val;
                        factor_set[row * VEC_LEN + col] = 1'b1;
                    end
                end
                default: begin
                    pending_rows.push_back(perturbed_row(rc, rs, row, n));
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        endtask

        task check_row(logic [39:0] data, logic [0:0] flag);
            row_result_t want;
            if (pending_rows.size() == 0) begin
                report_mismatch("result with no pending row request", '0, 64'(data));
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (want.sat) rows_saturated++;
            if (data[2:0] != want.core) begin
                report_mismatch("out_core", 64'(want.core), 64'(data[2:0]));
            end
            if (data[7:3] != want.sample) begin
                report_mismatch("out_sample", 64'(want.sample), 64'(data[7:3]));
            end
            if (data[39:8] != want.value) begin
                report_mismatch("perturbed_value", 64'(want.value), 64'(data[39:8]));
            end
            if (flag[0] != want.sat) begin
                report_mismatch("saturated", 64'(want.sat), 64'(flag[0]));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] row_core, [7:3] row_sample, [10:8] col_core, [15:11] col_sample,
    // [47:16] operand_value
    logic [47:0] s_tdata = '0;
    // [1:0] opcode
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [2:0] out_core, [7:3] out_sample, [39:8] perturbed_value
    logic [39:0] m_tdata;
    // [0] saturated
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [5:0]  cfg_data = '0;

    row_ledger   ledger = new;
    bit          steady = 1'b0;
    int unsigned items_sent = 0;
    int unsigned settings_used = 0;

    correlated_deviate_perturbation_unit #(
        .CORES       (CORES),
        .SAMPLES_MAX (SAMPLES_MAX),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly Q8.24 values near unity, with a share of full-range and extreme words.
    function automatic logic [31:0] draw_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1: return r;
            2: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return VAL_NEG1;
                endcase
            end
            3, 4: return {{4{r[27]}}, r[27:0]};
            default: return {{7{r[24]}}, r[24:0]};
        endcase
    endfunction

    // One item transfer, with an optional idle gap ahead of it.
    task automatic send_item(opcode_t op, logic [2:0] rc, logic [4:0] rs,
                             logic [2:0] cc, logic [4:0] cs, logic [31:0] val);
        if (!steady && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {val, cs, cc, rs, rc};
        do @(posedge aclk); while (!s_tready);
        ledger.note_item(op, rc, rs, cc, cs, val);
        items_sent++;
    endtask

    // Write both registers back to back; only called while the block is idle.
    task automatic configure(logic [5:0] samples, bit hold);
        logic [4:0] junk;
        logic [5:0] hold_word;
        junk = 5'($urandom);
        hold_word = {junk, hold};
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SAMPLES;
        cfg_data <= samples;
        do @(posedge aclk); while (!cfg_ready);
        ledger.set_config(CFG_SAMPLES, samples);
        cfg_index <= CFG_HOLD;
        cfg_data <= hold_word;
        do @(posedge aclk); while (!cfg_ready);
        ledger.set_config(CFG_HOLD, hold_word);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Wait for every pending row, then give a store item time to finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (ledger.pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write whatever a row request would read that has not been written yet.
    task automatic fill_row(logic [2:0] rc, logic [4:0] rs);
        int unsigned n, row, j;
        n = ledger.span();
        row = rc * n + rs;
        if (!ledger.nominal_set[row]) begin
            send_item(OP_WR_NOMINAL, rc, rs, 3'($urandom), 5'($urandom), draw_value());
        end
        if (!ledger.hold_reg) begin
            for (j = 0; j < CORES * n; j++) begin
                if (!ledger.deviate_set[j]) begin
                    send_item(OP_WR_DEVIATE, 3'(j / n), 5'(j % n), 3'($urandom),
                              5'($urandom), draw_value());
                end
                if (!ledger.factor_set[row * VEC_LEN + j]) begin
                    send_item(OP_WR_FACTOR, rc, rs, 3'(j / n), 5'(j % n), draw_value());
                end
            end
        end
    endtask

    // Directed items with one sample per core: saturation both ways,
    // round half up, and items with indexes out of range.
    task automatic directed_items();
        logic [31:0] devs [CORES];
        int unsigned c;
        devs = '{VAL_MAX, VAL_MIN, VAL_ONE, VAL_NEG1, 32'h0, VAL_HALF};
        send_item(OP_WR_NOMINAL, 3'd0, 5'd0, 3'd7, 5'd31, VAL_MAX);
        for (c = 0; c < CORES; c++) send_item(OP_WR_DEVIATE, 3'(c), 5'd0, 3'd0, 5'd0, devs[c]);
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd0, 5'd0, VAL_MAX);
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd1, 5'd0, VAL_MIN);
        for (c = 2; c < CORES; c++) send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'(c), 5'd0, 32'h0);
        send_item(OP_ROW, 3'd0, 5'd0, 3'd0, 5'd0, 32'h0);
        // Opposite signs drive the sum below the 32-bit range.
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd0, 5'd0, VAL_MIN);
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd1, 5'd0, VAL_MAX);
        send_item(OP_WR_NOMINAL, 3'd0, 5'd0, 3'd0, 5'd0, VAL_MIN);
        send_item(OP_ROW, 3'd0, 5'd0, 3'd7, 5'd31, VAL_NEG1);
        // A product of exactly minus one half LSB rounds up, leaving the nominal value.
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd0, 5'd0, 32'h0);
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd1, 5'd0, 32'h0);
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd5, 5'd0, VAL_NEG1);
        send_item(OP_WR_NOMINAL, 3'd0, 5'd0, 3'd0, 5'd0, VAL_ONE);
        send_item(OP_ROW, 3'd0, 5'd0, 3'd0, 5'd0, 32'h0);
        // Out-of-range row or column: nothing stored, nothing returned.
        send_item(OP_WR_NOMINAL, 3'd7, 5'd0, 3'd0, 5'd0, VAL_MAX);
        send_item(OP_ROW, 3'd0, 5'd31, 3'd0, 5'd0, 32'h0);
        send_item(OP_WR_FACTOR, 3'd0, 5'd0, 3'd6, 5'd0, VAL_MAX);
        send_item(OP_ROW, 3'd6, 5'd0, 3'd0, 5'd0, 32'h0);
    endtask

    // Random traffic under the current settings, until about count item
    // transfers have been sent, fill writes and noise included. Row requests
    // are preceded by the writes they need; about one item in eight is
    // out-of-range noise.
    task automatic random_phase(int unsigned count);
        int unsigned start, n, hot, pick;
        logic [2:0] rc, cc;
        logic [4:0] rs, cs;
        opcode_t op;
        start = items_sent;
        n = ledger.span();
        // With long rows, requests stay on one row per core to bound the fill traffic.
        hot = (ledger.hold_reg || n <= 8) ? n : 1;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 99);
            rc = 3'($urandom_range(0, CORES - 1));
            rs = 5'($urandom_range(0, n - 1));
            cc = 3'($urandom);
            cs = 5'($urandom);
            if (pick < 12) begin
                op = opcode_t'(2'($urandom_range(0, 3)));
                cc = 3'($urandom_range(0, CORES - 1));
                cs = 5'($urandom_range(0, n - 1));
                case ($urandom_range(0, 3))
                    0: rc = 3'($urandom_range(CORES, 7));
                    1: begin
                        if (n < SAMPLES_MAX) rs = 5'($urandom_range(n, 31));
                        else rc = 3'd7;
                    end
                    2: begin
                        op = OP_WR_FACTOR;
                        cc = 3'($urandom_range(CORES, 7));
                    end
                    default: begin
                        op = OP_WR_FACTOR;
                        if (n < SAMPLES_MAX) cs = 5'($urandom_range(n, 31));
                        else cc = 3'(CORES);
                    end
                endcase
                send_item(op, rc, rs, cc, cs, draw_value());
            end else begin
                if (pick < 42) begin
                    rs = 5'($urandom_range(0, hot - 1));
                    fill_row(rc, rs);
                    send_item(OP_ROW, rc, rs, cc, cs, $urandom);
                end else if (pick < 64) begin
                    rs = 5'($urandom_range(0, hot - 1));
                    send_item(OP_WR_FACTOR, rc, rs, 3'($urandom_range(0, CORES - 1)),
                              5'($urandom_range(0, n - 1)), draw_value());
                end else if (pick < 82) begin
                    send_item(OP_WR_DEVIATE, rc, rs, cc, cs, draw_value());
                end else begin
                    send_item(OP_WR_NOMINAL, rc, rs, cc, cs, draw_value());
                end
            end
        end
    endtask

    // Result side: check each transfer, then pick the next ready level.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) ledger.check_row(m_tdata, m_tuser);
            m_tready <= steady || ($urandom_range(0, 99) >= 34);
        end
    end

    // Main sequence.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        configure(6'd1, 1'b0);
        directed_items();

        // Each setting starts from an idle block.
        settle();
        configure(6'd0, 1'b0);
        random_phase(120);
        settle();
        configure(6'd3, 1'b1);
        random_phase(100);
        settle();
        configure(6'd2, 1'b0);
        random_phase(120);

        // A stretch with no idling on either side.
        settle();
        configure(6'd6, 1'b0);
        steady = 1'b1;
        random_phase(130);
        steady = 1'b0;

        settle();
        configure(6'd32, 1'b0);
        random_phase(40);
        settle();
        configure(6'd63, 1'b0);
        random_phase(20);
        settle();
        configure(6'd32, 1'b1);
        random_phase(100);
        settle();
        configure(6'd17, 1'b0);
        random_phase(40);
        settle();
        configure(6'd5, 1'b0);
        random_phase(120);
        settle();

        $display("Sent %0d item transfers under %0d register settings.",
                 items_sent, settings_used);
        $display("Checked %0d rows, %0d of them saturated; %0d mismatches.",
                 ledger.rows_checked, ledger.rows_saturated, ledger.mismatches);
        if (ledger.mismatches == 0) begin
            $display("correlated_deviate_perturbation_unit test passed");
        end else begin
            $display("correlated_deviate_perturbation_unit test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #8_000_000;
        $display("correlated_deviate_perturbation_unit test failed");
        $finish;
    end

endmodule
